[rtl/abd_pkg.sv]
// Shared types and constants for the audio beat detector.
// Holds the controller state type, controller/datapath command and status
// structs, register indexes and reset values. No dependencies.
package abd_pkg;

   // Default geometry
   localparam int NUM_CHANNELS_DEF = 8;
   localparam int HIST_DEPTH_DEF   = 16;

   // Field widths
   localparam int CHAN_W  = 6;
   localparam int MAG_W   = 16;
   localparam int LEVEL_W = 8;
   localparam int SENS_W  = 16;
   localparam int THR_W   = 8;
   localparam int CSR_W   = 16;

   // Register indexes
   localparam logic CSR_SENSITIVITY = 1'b0;
   localparam logic CSR_THRESHOLD   = 1'b1;

   // Register reset values: sensitivity 1.0 in Q8.8, threshold 1.5 in Q4.4
   localparam logic [SENS_W-1:0] SENS_RESET = 16'd256;
   localparam logic [THR_W-1:0]  THR_RESET  = 8'd24;

   // Intensity levels
   localparam logic [LEVEL_W-1:0] BEAT_LEVEL      = 8'd250;
   localparam logic [LEVEL_W-1:0] DECAY_HI_LIMIT  = 8'd150;
   localparam logic [LEVEL_W-1:0] DECAY_HI_STEP   = 8'd20;
   localparam logic [LEVEL_W-1:0] DECAY_MID_LIMIT = 8'd50;
   localparam logic [LEVEL_W-1:0] DECAY_MID_STEP  = 8'd5;
   localparam logic [LEVEL_W-1:0] DECAY_LO_LIMIT  = 8'd20;
   localparam logic [LEVEL_W-1:0] DECAY_LO_STEP   = 8'd1;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_DECIDE
   } abd_state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_en;   // write zeros at the sweep address
      logic load_item;  // capture the input transfer
      logic read_en;    // read history and channel stores, scale sample
      logic sum_en;     // form the new window sum
      logic commit;     // write back, update pointer, load result
   } abd_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last; // sweep is at its final address
      logic out_free;   // result register can take a new result
   } abd_status_type;

   // Three-step intensity decay
   function automatic logic [LEVEL_W-1:0] decay(input logic [LEVEL_W-1:0] v);
      logic [LEVEL_W-1:0] r;
      r = v;
      if (r >= DECAY_HI_LIMIT)  r = r - DECAY_HI_STEP;
      if (r >= DECAY_MID_LIMIT) r = r - DECAY_MID_STEP;
      if (r >= DECAY_LO_LIMIT)  r = r - DECAY_LO_STEP;
      return r;
   endfunction

endpackage

[rtl/abd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module abd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/abd_ctrl.sv]
// Controller state machine for the audio beat detector.
// Depends on abd_pkg for the state type and command/status structs.
module abd_ctrl
   import abd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  abd_status_type status,
   output abd_cmd_type    cmd
);

   abd_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_READ;
         ST_READ:   state_in = ST_CALC;
         ST_CALC:   state_in = ST_DECIDE;
         ST_DECIDE: if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_en = 1'b1;
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_READ:   cmd.read_en = 1'b1;
         ST_CALC:   cmd.sum_en  = 1'b1;
         ST_DECIDE: cmd.commit  = status.out_free;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

[rtl/abd_datapath.sv]
// Datapath of the audio beat detector: item registers, scaling multiply,
// window sum, beat compare, decay, history pointer, config and result regs.
// Depends on abd_pkg and abd_ram (history store and per-channel store).
module abd_datapath
   import abd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int HIST_DEPTH   = HIST_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  abd_cmd_type         cmd,
   output abd_status_type      status,
   // input item
   input  logic [CHAN_W-1:0]   in_channel,
   input  logic [MAG_W-1:0]    in_magnitude,
   input  logic                in_frame_end,
   // configuration
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_wdata,
   // result
   output logic                out_valid,
   input  logic                out_ready,
   output logic [CHAN_W-1:0]   out_channel,
   output logic [LEVEL_W-1:0]  out_intensity,
   output logic                out_beat
);

   localparam int PTR_W   = $clog2(HIST_DEPTH);
   localparam int CH_AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int HDEPTH  = NUM_CHANNELS * HIST_DEPTH;
   localparam int HR_AW   = $clog2(HDEPTH);
   localparam int WIDE_AW = CH_AW + PTR_W;
   localparam int SUM_W   = MAG_W + PTR_W;
   localparam int CMP_W   = SUM_W + THR_W;
   localparam int PROD_W  = MAG_W + SENS_W;
   localparam int CR_W    = SUM_W + LEVEL_W;

   // Configuration registers
   logic [SENS_W-1:0] sens_ff;
   logic [THR_W-1:0]  thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff <= SENS_RESET;
         thr_ff  <= THR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SENSITIVITY: sens_ff <= csr_wdata[SENS_W-1:0];
            CSR_THRESHOLD:   thr_ff  <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // Item registers
   logic [CHAN_W-1:0] ch_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic              fend_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         ch_ff   <= in_channel;
         mag_ff  <= in_magnitude;
         fend_ff <= in_frame_end;
      end
   end

   logic in_range;
   assign in_range = ({1'b0, ch_ff} < (CHAN_W+1)'(NUM_CHANNELS));

   // Shared history pointer
   logic [PTR_W-1:0] ptr_ff, ptr_in;

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.commit && fend_ff) begin
         ptr_in = (ptr_ff == '0) ? PTR_W'(HIST_DEPTH - 1) : ptr_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   // Store addresses for the current item
   logic [CH_AW-1:0]   ch_idx;
   logic [WIDE_AW-1:0] slot_wide;
   logic [HR_AW-1:0]   slot;

   assign ch_idx    = ch_ff[CH_AW-1:0];
   assign slot_wide = WIDE_AW'(ch_idx) * WIDE_AW'(HIST_DEPTH) + WIDE_AW'(ptr_ff);
   assign slot      = slot_wide[HR_AW-1:0];

   // Clearing sweep after reset
   logic [HR_AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   logic clr_chan;
   assign clr_chan          = ({1'b0, clr_addr_ff} < (HR_AW+1)'(NUM_CHANNELS));
   assign status.clear_last = (clr_addr_ff == HR_AW'(HDEPTH - 1));

   // Scale by sensitivity, truncate and saturate
   logic [PROD_W-1:0] prod;
   logic [MAG_W-1:0]  sample_ff;

   assign prod = mag_ff * sens_ff;

   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         sample_ff <= (prod[PROD_W-1:MAG_W+8] != '0) ? '1 : prod[MAG_W+7:8];
      end
   end

   // Stores
   logic [MAG_W-1:0] hist_rdata;
   logic [CR_W-1:0]  chan_rdata;
   logic             hist_we, chan_we;
   logic [HR_AW-1:0] hist_waddr;
   logic [CH_AW-1:0] chan_waddr;
   logic [MAG_W-1:0] hist_wdata;
   logic [CR_W-1:0]  chan_wdata;

   logic [SUM_W-1:0]   sum_ff;
   logic [LEVEL_W-1:0] level_old_ff;
   logic [CMP_W-1:0]   lhs_ff;
   logic [CMP_W-1:0]   rhs;
   logic               beat;
   logic [LEVEL_W-1:0] level;

   // Write-back mux: sweep zeros, otherwise the committed item
   always_comb begin
      if (cmd.clear_en) begin
         hist_we    = 1'b1;
         hist_waddr = clr_addr_ff;
         hist_wdata = '0;
         chan_we    = clr_chan;
         chan_waddr = clr_addr_ff[CH_AW-1:0];
         chan_wdata = '0;
      end else begin
         hist_we    = cmd.commit && in_range;
         hist_waddr = slot;
         hist_wdata = sample_ff;
         chan_we    = cmd.commit && in_range;
         chan_waddr = ch_idx;
         chan_wdata = {sum_ff, level};
      end
   end

   abd_ram #(
      .WIDTH (MAG_W),
      .DEPTH (HDEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_en   (cmd.read_en),
      .rd_addr (slot),
      .rd_data (hist_rdata)
   );

   abd_ram #(
      .WIDTH (CR_W),
      .DEPTH (NUM_CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (chan_we),
      .wr_addr (chan_waddr),
      .wr_data (chan_wdata),
      .rd_en   (cmd.read_en),
      .rd_addr (ch_idx),
      .rd_data (chan_rdata)
   );

   // Window sum update and left side of the compare (sample * depth * 16)
   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         sum_ff       <= chan_rdata[CR_W-1:LEVEL_W] - SUM_W'(hist_rdata)
                         + SUM_W'(sample_ff);
         level_old_ff <= chan_rdata[LEVEL_W-1:0];
         lhs_ff       <= (CMP_W'(sample_ff) * CMP_W'(HIST_DEPTH)) << 4;
      end
   end

   // Beat decision and intensity
   assign rhs   = CMP_W'(sum_ff) * CMP_W'(thr_ff);
   assign beat  = in_range && (lhs_ff > rhs);
   assign level = !in_range ? '0 : (beat ? BEAT_LEVEL : decay(level_old_ff));

   // Result register
   logic               out_valid_ff;
   logic [CHAN_W-1:0]  out_channel_ff;
   logic [LEVEL_W-1:0] out_intensity_ff;
   logic               out_beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_channel_ff   <= ch_ff;
         out_intensity_ff <= level;
         out_beat_ff      <= beat;
      end
   end

   assign status.out_free = !out_valid_ff || out_ready;
   assign out_valid       = out_valid_ff;
   assign out_channel     = out_channel_ff;
   assign out_intensity   = out_intensity_ff;
   assign out_beat        = out_beat_ff;

endmodule

[rtl/audio_beat_detector.sv]
// Audio beat detector: energy beat detection over a moving window per channel.
// Top level joining abd_ctrl and abd_datapath; depends on abd_pkg.
//
// Usage:
//  - req channel: one band magnitude per transfer. tdata carries channel and
//    weighted magnitude, tlast marks the last channel of a frame and steps the
//    shared history pointer back by one (wrapping to HIST_DEPTH-1).
//  - rsp channel: exactly one result per request transfer, in order. tdata
//    carries the channel and its updated intensity, tuser the beat flag.
//  - csr port: index 0 is the Q8.8 sensitivity, index 1 the Q4.4 threshold
//    multiplier. Write only while the block is idle.
//  - Timing: an item is taken in the idle state, then goes through read,
//    window-sum and decide steps; the result register loads when decide
//    commits. The history and channel stores are one-write, one-read RAMs used
//    read-modify-write, so a new item is taken only after the last one commits.
//  - Reset: registers return to their defaults, then a clearing pass zeroes
//    the stores, one history entry per cycle over all NUM_CHANNELS*HIST_DEPTH
//    entries, with req_tready low throughout.
//  - Stall: the result register holds a finished result while rsp_tready is
//    low; the next request is still taken and processed up to the decide
//    step, where it waits until the result register frees up.
module audio_beat_detector
   import abd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int HIST_DEPTH   = HIST_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request stream
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [23:0]        req_tdata,  // [5:0] channel, [21:6] weighted_magnitude
   input  logic               req_tlast,  // frame_end
   // result stream
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,  // [5:0] out_channel, [13:6] intensity
   output logic               rsp_tuser,  // beat
   // configuration
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   abd_cmd_type        cmd;
   abd_status_type     status;
   logic [CHAN_W-1:0]  out_channel;
   logic [LEVEL_W-1:0] out_intensity;

   abd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   abd_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .HIST_DEPTH   (HIST_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .in_channel    (req_tdata[CHAN_W-1:0]),
      .in_magnitude  (req_tdata[CHAN_W+MAG_W-1:CHAN_W]),
      .in_frame_end  (req_tlast),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_channel   (out_channel),
      .out_intensity (out_intensity),
      .out_beat      (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, out_intensity, out_channel};

endmodule

[rtl/abd_checker.sv]
// Port-level checks for audio_beat_detector, attached by bind.
// Depends on abd_pkg for field widths and the beat level.
module abd_checker
   import abd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // One item at a time: no request taken right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous item in progress");

   // A beat always reports full intensity
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[13:6] == BEAT_LEVEL)
      else $error("beat without beat level");

   // Unknown channels report zero intensity and no beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ({1'b0, rsp_tdata[5:0]} >= (CHAN_W+1)'(NUM_CHANNELS))
      |-> rsp_tdata[13:6] == '0 && !rsp_tuser)
      else $error("out-of-range channel produced activity");

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind audio_beat_detector abd_checker #(
   .NUM_CHANNELS (NUM_CHANNELS)
) u_abd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[verif/abd_beat_checker.sv]
`timescale 1ns / 100ps
// Result checker for the audio beat detector: watches the req, rsp and csr ports,
// predicts each channel's intensity and beat flag and compares them in order.
// Depends on abd_pkg for field widths, register indexes and level constants.
module abd_beat_checker
   import abd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int HIST_DEPTH   = HIST_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [23:0]      req_tdata,     // [5:0] channel, [21:6] weighted_magnitude
   input  logic             req_tlast,     // frame_end
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [15:0]      rsp_tdata,     // [5:0] out_channel, [13:6] intensity
   input  logic             rsp_tuser,     // beat
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               fail_count,
   output int               results_seen,
   output int               expected_left,
   output int               beats_seen
);

   typedef struct packed {
      logic [CHAN_W-1:0]  chan;
      logic [LEVEL_W-1:0] level;
      logic               beat;
   } pulse_type;

   // Own copy of the detector state
   logic [MAG_W-1:0]   ring_mem [NUM_CHANNELS*HIST_DEPTH];
   logic [31:0]        energy_sum [NUM_CHANNELS];
   logic [LEVEL_W-1:0] glow [NUM_CHANNELS];
   int unsigned        ring_ptr;
   logic [SENS_W-1:0]  gain_q88;
   logic [THR_W-1:0]   thr_q44;
   pulse_type          pending_pulses [$];

   // Scale, update the ring and window sum, then decide beat or decay
   function automatic pulse_type predict_pulse(input logic [CHAN_W-1:0] ch,
                                               input logic [MAG_W-1:0]  mag,
                                               input logic              fend);
      pulse_type   res;
      logic [31:0] scaled;
      logic [31:0] sum;
      logic [63:0] lhs;
      logic [63:0] rhs;
      int          slot;
      res.chan  = ch;
      res.level = '0;
      res.beat  = 1'b0;
      if (ch < NUM_CHANNELS) begin
         scaled = (32'(mag) * 32'(gain_q88)) >> 8;
         if (scaled > 32'hFFFF) scaled = 32'hFFFF;   // saturate to 16 bits
         slot = int'(ch) * HIST_DEPTH + int'(ring_ptr);
         sum  = energy_sum[ch] - 32'(ring_mem[slot]) + scaled;
         // sample > average * Q4.4 factor, with no division
         lhs  = 64'(scaled) * 64'(HIST_DEPTH) * 64'd16;
         rhs  = 64'(sum) * 64'(thr_q44);
         ring_mem[slot] = scaled[MAG_W-1:0];
         energy_sum[ch] = sum;
         if (lhs > rhs) begin
            res.beat  = 1'b1;
            res.level = BEAT_LEVEL;
         end else begin
            // cascaded decay, each step sees the previous one's output
            res.level = glow[ch];
            if (res.level >= DECAY_HI_LIMIT)  res.level = res.level - DECAY_HI_STEP;
            if (res.level >= DECAY_MID_LIMIT) res.level = res.level - DECAY_MID_STEP;
            if (res.level >= DECAY_LO_LIMIT)  res.level = res.level - DECAY_LO_STEP;
         end
         glow[ch] = res.level;
      end
      // frame end steps the shared pointer back, wrapping at zero
      if (fend) ring_ptr = (ring_ptr == 0) ? HIST_DEPTH - 1 : ring_ptr - 1;
      return res;
   endfunction

   always @(posedge clock) begin : track
      pulse_type want;
      pulse_type got;
      int        errs;
      int        got_one;
      errs    = 0;
      got_one = 0;
      if (reset) begin
         foreach (ring_mem[i]) ring_mem[i] = '0;
         foreach (energy_sum[i]) energy_sum[i] = '0;
         foreach (glow[i]) glow[i] = '0;
         ring_ptr = 0;
         gain_q88 = SENS_RESET;
         thr_q44  = THR_RESET;
         pending_pulses.delete();
         fail_count    <= 0;
         results_seen  <= 0;
         expected_left <= 0;
         beats_seen    <= 0;
      end else begin
         // register writes
         if (csr_wr_en) begin
            if (csr_index == CSR_SENSITIVITY)
               gain_q88 = csr_wdata[SENS_W-1:0];
            else if (csr_index == CSR_THRESHOLD)
               thr_q44 = csr_wdata[THR_W-1:0];
         end

         // result transfer against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got.chan  = rsp_tdata[CHAN_W-1:0];
            got.level = rsp_tdata[CHAN_W +: LEVEL_W];
            got.beat  = rsp_tuser;
            got_one   = 1;
            if (pending_pulses.size() == 0) begin
               $display("%0t: unexpected result, channel %0d intensity %0d beat %0b",
                        $time, got.chan, got.level, got.beat);
               errs++;
            end else begin
               want = pending_pulses.pop_front();
               if (got.chan !== want.chan) begin
                  $display("%0t: out_channel mismatch: expected %0d, got %0d",
                           $time, want.chan, got.chan);
                  errs++;
               end
               if (got.level !== want.level) begin
                  $display("%0t: intensity mismatch on channel %0d: expected %0d, got %0d",
                           $time, want.chan, want.level, got.level);
                  errs++;
               end
               if (got.beat !== want.beat) begin
                  $display("%0t: beat mismatch on channel %0d: expected %0b, got %0b",
                           $time, want.chan, want.beat, got.beat);
                  errs++;
               end
            end
         end

         // request transfer
         if (req_tvalid && req_tready)
            pending_pulses.push_back(predict_pulse(req_tdata[CHAN_W-1:0],
                                                   req_tdata[CHAN_W +: MAG_W], req_tlast));

         fail_count    <= fail_count + errs;
         results_seen  <= results_seen + got_one;
         beats_seen    <= beats_seen + ((got_one != 0 && got.beat === 1'b1) ? 1 : 0);
         expected_left <= pending_pulses.size();
      end
   end

endmodule

[verif/audio_beat_detector_test.sv]
`timescale 1ns / 100ps
// Testbench top for the audio beat detector: clock, reset, band-sample and
// register stimulus, result back-pressure and the verdict.
// Depends on abd_pkg, audio_beat_detector and abd_beat_checker.
module audio_beat_detector_test;
   import abd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 220;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic [23:0]      req_tdata  = '0;
   logic             req_tlast  = 1'b0;
   logic             rsp_tready = 1'b0;
   logic             csr_wr_en  = 1'b0;
   logic             csr_index  = CSR_SENSITIVITY;
   logic [CSR_W-1:0] csr_wdata  = '0;
   wire              req_tready;
   wire              rsp_tvalid;
   wire  [15:0]      rsp_tdata;
   wire              rsp_tuser;

   int          fail_count;
   int          results_seen;
   int          expected_left;
   int          beats_seen;
   int          items_sent    = 0;
   int          settings_used = 0;
   int          cycle_count   = 0;
   int unsigned sink_wait     = 0;
   bit          req_idle_on   = 1'b1;
   bit          rsp_idle_on   = 1'b1;

   audio_beat_detector u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   abd_beat_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .results_seen  (results_seen),
      .expected_left (expected_left),
      .beats_seen    (beats_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result back-pressure: after each transfer hold tready low for a randomly drawn wait
   always @(posedge clock) begin : rsp_pacing
      int unsigned draw;
      draw = rsp_idle_on ? $urandom_range(0, 7) : 0;
      if (rsp_tvalid && rsp_tready) begin
         sink_wait  <= draw;
         rsp_tready <= (draw == 0);
      end else if (sink_wait != 0) begin
         sink_wait  <= sink_wait - 1;
         rsp_tready <= (sink_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, items_sent - results_seen);
         $display("Some tests failed");
         $finish;
      end
   end

   // One band-sample transfer, after a random gap when idling is on
   task automatic send_band(input logic [CHAN_W-1:0] ch, input logic [MAG_W-1:0] mag,
                            input logic fend);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, mag, ch};
      req_tlast  <= fend;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Wait until every transfer sent so far has produced its result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
   endtask

   // Write both registers; spare high bits of the threshold write are random
   task automatic load_settings(input logic [SENS_W-1:0] sens, input logic [THR_W-1:0] thr);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SENSITIVITY;
      csr_wdata <= sens;
      @(posedge clock);
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= {8'($urandom), thr};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      logic [SENS_W-1:0] sens_list [6];
      logic [THR_W-1:0]  thr_list  [6];
      logic [MAG_W-1:0]  mag;
      int                phase_end;

      sens_list = '{16'd256, 16'hFFFF, 16'd0, 16'd1, 16'd384, 16'($urandom)};
      thr_list  = '{8'd24, 8'hFF, 8'd0, 8'd16, 8'd40, 8'($urandom)};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, empty window, beat then decay, pointer wrap,
      // out-of-range channels
      send_band(6'd0, 16'd0, 1'b0);
      send_band(6'd0, 16'hFFFF, 1'b0);
      repeat (3) send_band(6'd0, 16'd0, 1'b0);
      send_band(6'd63, 16'hFFFF, 1'b1);
      send_band(6'd8, 16'd1234, 1'b0);
      send_band(6'd7, 16'hFFFF, 1'b1);
      send_band(6'd1, 16'd1, 1'b0);
      send_band(6'd5, 16'd0, 1'b1);
      repeat (3) send_band(6'd0, 16'd0, 1'b0);

      // Full gain: scaling saturates
      load_settings(16'hFFFF, 8'hFF);
      send_band(6'd2, 16'hFFFF, 1'b0);
      send_band(6'd2, 16'd256, 1'b0);
      send_band(6'd2, 16'd1, 1'b0);
      send_band(6'd6, 16'd0, 1'b1);

      // Zero gain and zero threshold: zero samples never beat
      load_settings(16'd0, 8'd0);
      send_band(6'd3, 16'hFFFF, 1'b0);
      send_band(6'd3, 16'd40000, 1'b1);

      // Tiny gain: small magnitudes scale to zero, large ones beat on zero threshold
      load_settings(16'd1, 8'd0);
      send_band(6'd3, 16'hFFFF, 1'b0);
      send_band(6'd4, 16'd1, 1'b1);

      // Random phases: mostly whole frames of quiet bands with loud bursts,
      // the rest single transfers on any channel
      for (int p = 0; p < 6; p++) begin
         load_settings(sens_list[p], thr_list[p]);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) != 0) begin
               for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
                  case ($urandom_range(0, 15))
                     0:       mag = '0;
                     1:       mag = '1;
                     2, 3, 4: mag = MAG_W'($urandom);
                     default: mag = MAG_W'($urandom_range(0, 2000));
                  endcase
                  send_band(CHAN_W'(c), mag, c == NUM_CHANNELS_DEF - 1);
               end
            end else begin
               send_band(CHAN_W'($urandom), MAG_W'($urandom), 1'($urandom));
            end
         end
      end

      drain_results();
      repeat (10) @(posedge clock);

      if (expected_left != 0)
         $display("%0d expected results never arrived", expected_left);
      $display("Sent %0d band samples under %0d register settings; %0d beats reported.",
               items_sent, settings_used, beats_seen);
      $display("Stimulus covered out-of-range channels, gain saturation and pointer wrap.");
      if (fail_count == 0 && expected_left == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
